FILE: rtl/twtl_pkg.sv
// ----------------------------------------------------------------------------
// twtl_pkg
// shared types and constants of the two-way traffic light controller
// ----------------------------------------------------------------------------
package twtl_pkg;

    typedef enum logic [1:0] {
        MODE_RUN   = 2'd0,
        MODE_RED   = 2'd1,
        MODE_AMBER = 2'd2,
        MODE_GREEN = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_RED_GREEN = 2'd0,
        PH_RED_AMBER = 2'd1,
        PH_GREEN_RED = 2'd2,
        PH_AMBER_RED = 2'd3
    } t_phase;

    // input item bit positions
    localparam int IN_MODE  = 0;
    localparam int IN_INC   = 1;
    localparam int IN_SET   = 2;
    localparam int IN_TICK  = 3;
    localparam int IN_BLINK = 4;
    localparam int IN_BITS  = 5;

    // active-low lamp drive patterns
    localparam logic [5:0] LAMP_RED_GREEN = 6'h1e;
    localparam logic [5:0] LAMP_RED_AMBER = 6'h1d;
    localparam logic [5:0] LAMP_GREEN_RED = 6'h33;
    localparam logic [5:0] LAMP_AMBER_RED = 6'h2b;
    localparam logic [5:0] LAMP_CFG_RED   = 6'h1b;
    localparam logic [5:0] LAMP_CFG_AMBER = 6'h2d;
    localparam logic [5:0] LAMP_CFG_GREEN = 6'h36;
    localparam logic [5:0] BLINK_RED      = 6'h24;
    localparam logic [5:0] BLINK_AMBER    = 6'h12;
    localparam logic [5:0] BLINK_GREEN    = 6'h09;

    localparam int EDIT_WRAP   = 100;
    localparam int RESET_RED   = 5;
    localparam int RESET_AMBER = 2;
    localparam int RESET_GREEN = 3;

    function automatic logic [5:0] phase_lamps(input t_phase ph);
        logic [5:0] v;
        case (ph)
            PH_RED_GREEN: v = LAMP_RED_GREEN;
            PH_RED_AMBER: v = LAMP_RED_AMBER;
            PH_GREEN_RED: v = LAMP_GREEN_RED;
            default:      v = LAMP_AMBER_RED;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] blink_mask(input t_mode m);
        logic [5:0] v;
        case (m)
            MODE_RED:   v = BLINK_RED;
            MODE_AMBER: v = BLINK_AMBER;
            MODE_GREEN: v = BLINK_GREEN;
            default:    v = 6'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/twtl_bcd.sv
// ----------------------------------------------------------------------------
// twtl_bcd
// splits a small binary value into tens and ones digits (4 bits each)
// ----------------------------------------------------------------------------
module twtl_bcd
    import twtl_pkg::*;
#(
    parameter int WIDTH = 7
) (
    input  logic [WIDTH-1:0] i_value,
    output logic [3:0]       o_tens,
    output logic [3:0]       o_ones
);

    // x / 10 == (x * 205) >> 11, exact for x below 1029
    localparam int RECIP = 205;
    localparam int SHIFT = 11;
    localparam int PW    = WIDTH + 8;

    logic [PW-1:0]       prod;
    logic [PW-1-SHIFT:0] quot;
    logic [WIDTH-1:0]    rem;

    assign prod   = PW'(i_value) * PW'(RECIP);
    assign quot   = prod[PW-1:SHIFT];
    assign rem    = i_value - WIDTH'(WIDTH'(quot) * WIDTH'(10));
    assign o_tens = 4'(quot);
    assign o_ones = rem[3:0];

endmodule

FILE: rtl/two_way_traffic_light_controller_unit.sv
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller_unit
// two-way traffic light controller with red, amber and green edit modes
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one event item per handshake: mode, inc and set presses,
//   the one-second tick and the blink tick, one bit each
//   m_axis returns exactly one result item per event: lamp states, mode,
//   phase and the four display digits, all taken after the event
// throughput
//   an event is held in the input register, then processed in one pass of
//   next-state logic into the result register; one event per cycle is
//   sustained while m_axis_tready is high, and the next-state pass
//   includes the digit split (constant multiply)
// stalls
//   while m_axis_tready is low the result register holds; one more event
//   waits in the input register, then s_axis_tready drops
// reset
//   i_rst_n low (synchronous) empties both registers and loads auto mode,
//   phase red-green, countdowns 5/3, durations 5/2/3, edit value 5
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller_unit
    import twtl_pkg::*;
#(
    parameter int TIME_WIDTH = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode_press, inc_press, set_press, second_tick, blink_tick, 3 zero bits
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lamps[5:0], op_mode[7:6], phase[9:8], digit_a_tens[13:10],
    // digit_a_ones[17:14], digit_b_tens[21:18], digit_b_ones[25:22], zeros
    output logic [31:0] m_axis_tdata
);

    localparam int TW = TIME_WIDTH;

    // input register
    logic                r_in_vld;
    logic [IN_BITS-1:0]  r_in_data;
    // result register
    logic                r_out_vld;
    logic [31:0]         r_out_data;
    logic [31:0]         n_out_data;

    // controller state
    t_mode               r_mode,   n_mode;
    t_phase              r_phase,  n_phase;
    logic [TW-1:0]       r_cnt_a,  n_cnt_a;
    logic [TW-1:0]       r_cnt_b,  n_cnt_b;
    logic [TW-1:0]       r_red,    n_red;
    logic [TW-1:0]       r_amber,  n_amber;
    logic [TW-1:0]       r_green,  n_green;
    logic [TW-1:0]       r_edit,   n_edit;
    logic [5:0]          r_lamp,   n_lamp;

    logic                advance;
    logic [TW-1:0]       disp_b;
    logic [3:0]          a_tens, a_ones, b_tens, b_ones;
    logic [3:0]          dig_a_tens, dig_a_ones;

    // an event moves on when the result register is free or being drained
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_mode    <= MODE_RUN;
            r_phase   <= PH_RED_GREEN;
            r_cnt_a   <= TW'(RESET_RED);
            r_cnt_b   <= TW'(RESET_GREEN);
            r_red     <= TW'(RESET_RED);
            r_amber   <= TW'(RESET_AMBER);
            r_green   <= TW'(RESET_GREEN);
            r_edit    <= TW'(RESET_RED);
            r_lamp    <= LAMP_RED_GREEN;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
                r_mode    <= n_mode;
                r_phase   <= n_phase;
                r_cnt_a   <= n_cnt_a;
                r_cnt_b   <= n_cnt_b;
                r_red     <= n_red;
                r_amber   <= n_amber;
                r_green   <= n_green;
                r_edit    <= n_edit;
                r_lamp    <= n_lamp;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    // next state for the event in the input register
    always_comb begin : p_next
        logic [TW-1:0] ca, cb, ev, t_r, t_a, t_g;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_red   = r_red;
        n_amber = r_amber;
        n_green = r_green;
        n_edit  = r_edit;
        n_lamp  = r_lamp;
        ca      = r_cnt_a;
        cb      = r_cnt_b;
        ev      = r_edit;
        t_r     = r_red;
        t_a     = r_amber;
        t_g     = r_green;

        if (r_in_data[IN_MODE]) begin
            // a mode press does nothing else in this event
            case (r_mode)
                MODE_RUN: begin
                    n_mode = MODE_RED;
                    n_edit = r_red;
                    n_lamp = LAMP_CFG_RED;
                end
                MODE_RED: begin
                    n_mode = MODE_AMBER;
                    n_edit = r_amber;
                    n_lamp = LAMP_CFG_AMBER;
                end
                MODE_AMBER: begin
                    n_mode = MODE_GREEN;
                    n_edit = r_green;
                    n_lamp = LAMP_CFG_GREEN;
                end
                default: begin
                    n_mode  = MODE_RUN;
                    n_phase = PH_RED_GREEN;
                    n_cnt_a = r_red;
                    n_cnt_b = r_green;
                    n_lamp  = LAMP_RED_GREEN;
                end
            endcase
        end else if (r_mode == MODE_RUN) begin
            // lamps follow the phase held before this event
            n_lamp = phase_lamps(r_phase);
            if (r_in_data[IN_TICK]) begin
                if (ca != '0) ca = ca - TW'(1);
                if (cb != '0) cb = cb - TW'(1);
            end
            case (r_phase)
                PH_RED_GREEN: begin
                    if (cb == '0) begin
                        cb      = r_amber;
                        n_phase = PH_RED_AMBER;
                    end
                end
                PH_RED_AMBER: begin
                    if (cb == '0) begin
                        cb      = r_red;
                        ca      = r_green;
                        n_phase = PH_GREEN_RED;
                    end
                end
                PH_GREEN_RED: begin
                    if (ca == '0) begin
                        ca      = r_amber;
                        n_phase = PH_AMBER_RED;
                    end
                end
                default: begin
                    if (ca == '0) begin
                        ca      = r_red;
                        cb      = r_green;
                        n_phase = PH_RED_GREEN;
                    end
                end
            endcase
            n_cnt_a = ca;
            n_cnt_b = cb;
        end else begin
            // edit modes: blink, then increment, then set
            if (r_in_data[IN_BLINK]) begin
                n_lamp = r_lamp ^ blink_mask(r_mode);
            end
            if (r_in_data[IN_INC]) begin
                ev = ev + TW'(1);
                if (ev == TW'(EDIT_WRAP)) begin
                    ev = (r_mode == MODE_RED) ? TW'(2) : TW'(1);
                end
            end
            if (r_in_data[IN_SET]) begin
                case (r_mode)
                    MODE_RED: begin
                        if (ev < TW'(2)) ev = TW'(2);
                        t_r = ev;
                        if (t_a >= t_r) t_a = t_r - TW'(1);
                        if (t_a == '0) t_a = TW'(1);
                        t_g = t_r - t_a;
                    end
                    MODE_AMBER: begin
                        t_a = (ev == '0) ? TW'(1) : ev;
                        if (t_a >= r_red) begin
                            t_a = (r_red > TW'(1)) ? r_red - TW'(1) : TW'(1);
                        end
                        t_g = r_red - t_a;
                        if (t_g == '0) begin
                            t_g = TW'(1);
                            t_a = r_red - TW'(1);
                        end
                        ev = t_a;
                    end
                    default: begin
                        t_g = (ev == '0) ? TW'(1) : ev;
                        if (t_g >= r_red) t_g = r_red - TW'(1);
                        t_a = r_red - t_g;
                        if (t_a == '0) begin
                            t_a = TW'(1);
                            t_g = r_red - TW'(1);
                        end
                        ev = t_g;
                    end
                endcase
            end
            n_edit  = ev;
            n_red   = t_r;
            n_amber = t_a;
            n_green = t_g;
        end
    end

    // display digits
    assign disp_b = (n_mode == MODE_RUN) ? n_cnt_b : n_edit;

    twtl_bcd #(.WIDTH(TW)) u_bcd_a (
        .i_value (n_cnt_a),
        .o_tens  (a_tens),
        .o_ones  (a_ones)
    );

    twtl_bcd #(.WIDTH(TW)) u_bcd_b (
        .i_value (disp_b),
        .o_tens  (b_tens),
        .o_ones  (b_ones)
    );

    // edit modes show 0 and the mode number plus one on the a digits
    assign dig_a_tens = (n_mode == MODE_RUN) ? a_tens : 4'd0;
    assign dig_a_ones = (n_mode == MODE_RUN) ? a_ones : 4'(n_mode) + 4'd1;

    assign n_out_data = {6'd0, b_ones, b_tens, dig_a_ones, dig_a_tens,
                         n_phase, n_mode, ~n_lamp};

    // state only changes when an event moves into the result register
    a_hold_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> ($stable(r_mode) && $stable(r_phase)
            && $stable(r_red) && $stable(r_edit)))
        else $error("state changed while the result was stalled");

    // green plus amber always equals red
    a_sum_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        TW'(r_green + r_amber) == r_red)
        else $error("green plus amber differs from red");

    // red duration never below two
    a_red_min : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_red >= TW'(2))
        else $error("red duration below two");

    // result carries the mode that the event left behind
    a_out_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (m_axis_tdata[7:6] == r_mode))
        else $error("result mode does not match state");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-way traffic light controller unit
//
// event items go in on s_axis, result items come back on m_axis
// scoreboard class tracks mode, phase, both countdowns, the three
// durations, the edit value and the lamp drive
// each accepted event queues the expected lamps, mode, phase and digits,
// each returned item is checked against the oldest entry
//
// stimulus order:
//   - directed run through the first two phase changes and all three edit
//     modes, including the amber and green duration clamps
//   - random events, biased by the predicted mode
//   - long increment runs among the random events, so the edit value wraps at 100
// both sides idle at random, the receiver holds off once for a long stretch
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twtl_pkg::*;

    localparam int TW         = 7;
    localparam int N_RANDOM   = 1300;
    localparam int IDLE_LIMIT = 5000;

    localparam logic [4:0] EV_NONE  = 5'd0;
    localparam logic [4:0] EV_MODE  = 5'(1 << IN_MODE);
    localparam logic [4:0] EV_INC   = 5'(1 << IN_INC);
    localparam logic [4:0] EV_SET   = 5'(1 << IN_SET);
    localparam logic [4:0] EV_TICK  = 5'(1 << IN_TICK);
    localparam logic [4:0] EV_BLINK = 5'(1 << IN_BLINK);

    typedef struct {
        logic [5:0] lamps;
        t_mode      mode;
        t_phase     phase;
        logic [3:0] a_tens;
        logic [3:0] a_ones;
        logic [3:0] b_tens;
        logic [3:0] b_ones;
    } t_light_view;

    class light_scoreboard;
        t_mode         mode;
        t_phase        phase;
        logic [TW-1:0] cnt_a, cnt_b, red_t, amber_t, green_t, edit_v;
        logic [5:0]    drive;     // active-low lamp levels
        t_light_view   pending_views[$];
        int            errors;
        int            checked;

        function new();
            mode    = MODE_RUN;
            phase   = PH_RED_GREEN;
            red_t   = TW'(RESET_RED);
            amber_t = TW'(RESET_AMBER);
            green_t = TW'(RESET_GREEN);
            edit_v  = TW'(RESET_RED);
            cnt_a   = TW'(RESET_RED);
            cnt_b   = TW'(RESET_GREEN);
            drive   = LAMP_RED_GREEN;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return pending_views.size();
        endfunction

        function void enter_next_mode();
            case (mode)
                MODE_RUN:   mode = MODE_RED;
                MODE_RED:   mode = MODE_AMBER;
                MODE_AMBER: mode = MODE_GREEN;
                default:    mode = MODE_RUN;
            endcase
            case (mode)
                MODE_RUN: begin
                    phase = PH_RED_GREEN;
                    cnt_a = red_t;
                    cnt_b = green_t;
                    drive = LAMP_RED_GREEN;
                end
                MODE_RED: begin
                    edit_v = red_t;
                    drive  = LAMP_CFG_RED;
                end
                MODE_AMBER: begin
                    edit_v = amber_t;
                    drive  = LAMP_CFG_AMBER;
                end
                default: begin
                    edit_v = green_t;
                    drive  = LAMP_CFG_GREEN;
                end
            endcase
        endfunction

        function void run_phase(logic tick);
            case (phase)
                PH_RED_GREEN: drive = LAMP_RED_GREEN;
                PH_RED_AMBER: drive = LAMP_RED_AMBER;
                PH_GREEN_RED: drive = LAMP_GREEN_RED;
                default:      drive = LAMP_AMBER_RED;
            endcase
            if (tick) begin
                if (cnt_a != 0) cnt_a = cnt_a - 1'b1;
                if (cnt_b != 0) cnt_b = cnt_b - 1'b1;
            end
            // only the countdown of the changing direction ends a phase
            case (phase)
                PH_RED_GREEN: if (cnt_b == 0) begin
                    cnt_b = amber_t;
                    phase = PH_RED_AMBER;
                end
                PH_RED_AMBER: if (cnt_b == 0) begin
                    cnt_b = red_t;
                    cnt_a = green_t;
                    phase = PH_GREEN_RED;
                end
                PH_GREEN_RED: if (cnt_a == 0) begin
                    cnt_a = amber_t;
                    phase = PH_AMBER_RED;
                end
                default: if (cnt_a == 0) begin
                    cnt_a = red_t;
                    cnt_b = green_t;
                    phase = PH_RED_GREEN;
                end
            endcase
        endfunction

        // keeps green + amber == red after every store
        function void store_duration();
            logic [TW-1:0] v;
            case (mode)
                MODE_RED: begin
                    if (edit_v < 2) edit_v = TW'(2);
                    red_t = edit_v;
                    if (amber_t >= red_t) amber_t = red_t - 1'b1;
                    if (amber_t == 0) amber_t = TW'(1);
                    green_t = red_t - amber_t;
                end
                MODE_AMBER: begin
                    v = (edit_v == 0) ? TW'(1) : edit_v;
                    if (v >= red_t) v = (red_t > 1) ? red_t - 1'b1 : TW'(1);
                    amber_t = v;
                    green_t = red_t - amber_t;
                    if (green_t == 0) begin
                        green_t = TW'(1);
                        amber_t = red_t - 1'b1;
                    end
                    edit_v = amber_t;
                end
                default: begin
                    v = (edit_v == 0) ? TW'(1) : edit_v;
                    if (v >= red_t) v = red_t - 1'b1;
                    green_t = v;
                    amber_t = red_t - green_t;
                    if (amber_t == 0) begin
                        amber_t = TW'(1);
                        green_t = red_t - 1'b1;
                    end
                    edit_v = green_t;
                end
            endcase
        endfunction

        function void edit_step(logic inc, logic set, logic blink);
            if (blink) begin
                case (mode)
                    MODE_RED:   drive = drive ^ BLINK_RED;
                    MODE_AMBER: drive = drive ^ BLINK_AMBER;
                    default:    drive = drive ^ BLINK_GREEN;
                endcase
            end
            if (inc) begin
                edit_v = edit_v + 1'b1;
                if (edit_v == EDIT_WRAP) edit_v = (mode == MODE_RED) ? TW'(2) : TW'(1);
            end
            if (set) store_duration();
        endfunction

        function t_light_view current_view();
            t_light_view v;
            v.lamps = ~drive;
            v.mode  = mode;
            v.phase = phase;
            if (mode == MODE_RUN) begin
                v.a_tens = 4'(cnt_a / 10);
                v.a_ones = 4'(cnt_a % 10);
                v.b_tens = 4'(cnt_b / 10);
                v.b_ones = 4'(cnt_b % 10);
            end else begin
                v.a_tens = 4'd0;
                v.a_ones = {2'b00, mode} + 4'd1;
                v.b_tens = 4'(edit_v / 10);
                v.b_ones = 4'(edit_v % 10);
            end
            return v;
        endfunction

        // a mode press takes the whole step
        function void note_event(logic [4:0] ev);
            if (ev[IN_MODE]) enter_next_mode();
            else if (mode == MODE_RUN) run_phase(ev[IN_TICK]);
            else edit_step(ev[IN_INC], ev[IN_SET], ev[IN_BLINK]);
            pending_views.push_back(current_view());
        endfunction

        function void diff(string what, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, exp_v, act_v);
            end
        endfunction

        function void check_lights(logic [31:0] d);
            t_light_view e;
            checked++;
            if (pending_views.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, d);
                return;
            end
            e = pending_views.pop_front();
            diff("lamps", e.lamps, d[5:0]);
            diff("op_mode", e.mode, d[7:6]);
            diff("phase", e.phase, d[9:8]);
            diff("digit_a_tens", e.a_tens, d[13:10]);
            diff("digit_a_ones", e.a_ones, d[17:14]);
            diff("digit_b_tens", e.b_tens, d[21:18]);
            diff("digit_b_ones", e.b_ones, d[25:22]);
            diff("padding", 0, d[31:26]);
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;  // mode, inc, set, tick, blink, 3 zeros
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // lamps, op_mode, phase, four digits

    light_scoreboard sb = new();
    int              edit_run = 0;      // items left in a forced increment run
    logic [4:0]      directed_evs[$];

    always #5 i_clk = ~i_clk;

    two_way_traffic_light_controller_unit #(
        .TIME_WIDTH(TW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // biased on the predicted mode so that phases run out and edits land
    function automatic logic [4:0] pick_event();
        logic [4:0] ev;
        ev = 5'($urandom);
        if ($urandom_range(0, 19) == 0) return ev;   // plain noise
        if (sb.mode == MODE_RUN) begin
            ev[IN_MODE] = ($urandom_range(0, 79) == 0);
            ev[IN_TICK] = ($urandom_range(0, 3) != 0);
        end else if (edit_run > 0) begin
            edit_run--;
            ev[IN_MODE] = 1'b0;
            ev[IN_INC]  = 1'b1;
            ev[IN_SET]  = ($urandom_range(0, 19) == 0);
        end else begin
            ev[IN_MODE] = ($urandom_range(0, 24) == 0);
            ev[IN_INC]  = ($urandom_range(0, 2) == 0);
            ev[IN_SET]  = ($urandom_range(0, 5) == 0);
        end
        // entering an edit mode: sometimes step all the way past the wrap
        if (ev[IN_MODE] && sb.mode != MODE_GREEN && $urandom_range(0, 2) == 0)
            edit_run = $urandom_range(90, 140);
        return ev;
    endfunction

    task automatic push_event(input logic [4:0] ev);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ev};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_event(ev);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side: every accepted item is checked
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_lights(m_axis_tdata);
    end

    // receiver readiness: random stalls, quiet stretches and one long hold-off
    initial begin
        int  on_len;
        int  off_len;
        bit  long_done;
        long_done = 1'b0;
        wait (i_rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            on_len = $urandom_range(1, 24);
            repeat (on_len) @(posedge i_clk);
            if (!long_done && sb.checked >= 500) begin
                off_len   = 400;
                long_done = 1'b1;
            end else if ((sb.checked / 250) % 3 == 1) begin
                off_len = 0;
            end else begin
                off_len = gap_len();
            end
            if (off_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("[two_way_traffic_light_controller_unit] ERROR");
        $finish;
    end

    // sender
    initial begin
        int n;
        // phase walk, noise in auto, then each edit mode, with the amber and green clamps
        directed_evs = '{
            EV_NONE, EV_TICK, EV_TICK | EV_INC | EV_SET | EV_BLINK,
            EV_TICK, EV_TICK, EV_TICK,
            EV_MODE | EV_INC | EV_SET | EV_TICK | EV_BLINK,
            EV_BLINK, EV_BLINK, EV_INC | EV_SET | EV_BLINK, EV_TICK,
            EV_MODE,
            EV_INC | EV_SET, EV_INC | EV_SET, EV_INC | EV_SET, EV_INC | EV_SET,
            EV_BLINK,
            EV_MODE,
            EV_INC | EV_SET, EV_INC | EV_SET, EV_INC | EV_SET, EV_INC | EV_SET,
            EV_INC | EV_SET,
            EV_MODE, EV_TICK
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_evs[k]) begin
            push_event(directed_evs[k]);
            idle_for(gap_len());
        end
        drain_wait();

        for (n = 0; n < N_RANDOM; n++) begin
            push_event(pick_event());
            if ((n / 200) % 3 != 2) idle_for(gap_len());
            if (n % 350 == 349) drain_wait();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[two_way_traffic_light_controller_unit] OK");
        else
            $display("[two_way_traffic_light_controller_unit] ERROR");
        $finish;
    end

endmodule

FILE: two_way_traffic_light_controller_unit.f
rtl/twtl_pkg.sv
rtl/twtl_bcd.sv
rtl/two_way_traffic_light_controller_unit.sv
test/tb.sv
